/* rtl/core/utf8_stream_decode_fold_assert.svh */
// Assertion macros shared by the UTF-8 decode and fold RTL.
// Stand-alone header; the including module supplies clock, reset and signals.
`ifndef UTF8_STREAM_DECODE_FOLD_ASSERT_SVH
`define UTF8_STREAM_DECODE_FOLD_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UTF8SD_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8sd assertion failed");

// Next-cycle implication, disabled during reset.
`define UTF8SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8sd assertion failed");

`endif

/* rtl/core/utf8sd_pkg.sv */
// Types and constants for the UTF-8 stream decoder with lower-case fold.
// No dependencies; used by every module of the block.
package utf8sd_pkg;

  localparam int CP_W        = 21;
  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Sequence lengths announced by a lead byte.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // Lower-case fold ranges.
  localparam logic [CP_W-1:0] ASCII_UPPER_A   = 21'h00041;
  localparam logic [CP_W-1:0] ASCII_UPPER_Z   = 21'h0005A;
  localparam logic [CP_W-1:0] CYR_UPPER_FIRST = 21'h00410;
  localparam logic [CP_W-1:0] CYR_UPPER_LAST  = 21'h0042F;
  localparam logic [CP_W-1:0] FOLD_OFFSET     = 21'h00020;
  localparam logic [CP_W-1:0] CYR_IO_UPPER    = 21'h00401;
  localparam logic [CP_W-1:0] CYR_IO_LOWER    = 21'h00451;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] folded;
    logic            raw;
    logic            last;
  } entry_t;

  typedef struct packed {
    entry_t [MAX_RESULTS-1:0] e;
    logic [CNT_W-1:0]         count;
  } burst_t;

endpackage

/* rtl/core/utf8sd_decode.sv */
// Decode stage: sequence state registers and the single-pass decode of one byte.
// Depends on utf8sd_pkg and utf8_stream_decode_fold_assert.svh.
`include "utf8_stream_decode_fold_assert.svh"

module utf8sd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        data_byte,
  input  logic              end_of_string,
  output utf8sd_pkg::burst_t burst
);
  import utf8sd_pkg::*;

  localparam int NCAND = 7;

  logic [2:0][7:0] held_bytes, held_bytes_next;
  logic [1:0]      held_count, held_count_next;
  logic [2:0]      exp_len, exp_len_next;

  logic [2:0][7:0] post_bytes;
  logic [1:0]      post_count;
  logic [2:0]      post_len;

  logic            is_ascii, is_cont, holding, complete, append, break_seq, fresh;
  logic [2:0]      lead_len;
  logic [CP_W-1:0] assembled, primary_cp;
  entry_t          cand [NCAND];
  logic [NCAND-1:0] cand_en;
  logic [CNT_W-1:0] n;

  function automatic logic [CP_W-1:0] fold_lower(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] r;
    r = cp;
    if (cp >= ASCII_UPPER_A && cp <= ASCII_UPPER_Z) begin
      r = cp + FOLD_OFFSET;
    end else if (cp >= CYR_UPPER_FIRST && cp <= CYR_UPPER_LAST) begin
      r = cp + FOLD_OFFSET;
    end else if (cp == CYR_IO_UPPER) begin
      r = CYR_IO_LOWER;
    end
    return r;
  endfunction

  function automatic entry_t raw_entry(input logic [7:0] b);
    entry_t t;
    t.cp     = {{(CP_W-8){1'b0}}, b};
    t.folded = {{(CP_W-8){1'b0}}, b};
    t.raw    = 1'b1;
    t.last   = 1'b0;
    return t;
  endfunction

  always_comb begin
    is_ascii = ~data_byte[7];
    is_cont  = (data_byte[7:6] == 2'b10);
    if (data_byte[7:5] == 3'b110) begin
      lead_len = LEN_2;
    end else if (data_byte[7:4] == 4'b1110) begin
      lead_len = LEN_3;
    end else if (data_byte[7:3] == 5'b11110) begin
      lead_len = LEN_4;
    end else begin
      lead_len = LEN_NONE;
    end

    holding   = (held_count != 2'd0);
    complete  = holding && is_cont && ((3'(held_count) + 3'd1) == exp_len);
    append    = holding && is_cont && !complete;
    break_seq = holding && !is_cont;
    fresh     = !holding || break_seq;

    case (exp_len)
      LEN_2:   assembled = {10'd0, held_bytes[0][4:0], data_byte[5:0]};
      LEN_3:   assembled = {5'd0, held_bytes[0][3:0], held_bytes[1][5:0], data_byte[5:0]};
      default: assembled = {held_bytes[0][2:0], held_bytes[1][5:0], held_bytes[2][5:0],
                            data_byte[5:0]};
    endcase
    primary_cp = complete ? assembled : {{(CP_W-8){1'b0}}, data_byte};

    // State after the byte itself, before any end-of-string flush.
    post_bytes = held_bytes;
    post_count = held_count;
    post_len   = exp_len;
    if (complete) begin
      post_count = 2'd0;
      post_len   = LEN_NONE;
    end else if (append) begin
      post_bytes[held_count] = data_byte;
      post_count = held_count + 2'd1;
    end else if (fresh) begin
      post_bytes[0] = data_byte;
      post_count = (lead_len != LEN_NONE) ? 2'd1 : 2'd0;
      post_len   = lead_len;
    end

    // Held bytes of a broken sequence go first, then the new byte, then
    // anything the end of the string leaves behind.
    for (int i = 0; i < 3; i++) begin
      cand[i]       = raw_entry(held_bytes[i]);
      cand_en[i]    = break_seq && (2'(i) < held_count);
      cand[4+i]     = raw_entry(post_bytes[i]);
      cand_en[4+i]  = end_of_string && (2'(i) < post_count);
    end
    cand[3].cp     = primary_cp;
    cand[3].folded = fold_lower(primary_cp);
    cand[3].raw    = fresh && !is_ascii;
    cand[3].last   = 1'b0;
    cand_en[3]     = complete || (fresh && lead_len == LEN_NONE);

    burst = '0;
    n     = '0;
    for (int k = 0; k < NCAND; k++) begin
      if (cand_en[k] && n < CNT_W'(MAX_RESULTS)) begin
        burst.e[n[1:0]] = cand[k];
        n = n + 1'b1;
      end
    end
    if (n != '0) begin
      burst.e[2'(n - 1'b1)].last = 1'b1;
    end
    burst.count = n;

    if (end_of_string) begin
      held_bytes_next = '0;
      held_count_next = 2'd0;
      exp_len_next    = LEN_NONE;
    end else begin
      held_bytes_next = post_bytes;
      held_count_next = post_count;
      exp_len_next    = (post_count == 2'd0) ? LEN_NONE : post_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes <= '0;
      held_count <= 2'd0;
      exp_len    <= LEN_NONE;
    end else if (advance) begin
      held_bytes <= held_bytes_next;
      held_count <= held_count_next;
      exp_len    <= exp_len_next;
    end
  end

  `UTF8SD_ASSERT(held_len_ok, clk, rst, held_count != 2'd0, (exp_len >= LEN_2) && (exp_len <= LEN_4) && (3'(held_count) < exp_len))
  `UTF8SD_ASSERT(idle_len_clear, clk, rst, held_count == 2'd0, exp_len == LEN_NONE)
  `UTF8SD_ASSERT_NEXT(eos_clears_state, clk, rst, advance && end_of_string, held_count == 2'd0)

endmodule

/* rtl/core/utf8sd_burst.sv */
// Result register: holds the results of one byte and hands them out in order.
// Depends on utf8sd_pkg and utf8_stream_decode_fold_assert.svh.
`include "utf8_stream_decode_fold_assert.svh"

module utf8sd_burst (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  utf8sd_pkg::burst_t           burst,
  output logic                         can_load,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [utf8sd_pkg::CP_W-1:0]  code_point,
  output logic [utf8sd_pkg::CP_W-1:0]  folded_point,
  output logic                         raw_fallback,
  output logic                         run_last
);
  import utf8sd_pkg::*;

  entry_t           slots [MAX_RESULTS];
  logic [CNT_W-1:0] cnt;
  logic             take;

  assign out_valid    = (cnt != '0);
  assign take         = out_valid && out_ready;
  // A new burst may enter as the final result of the current one leaves.
  assign can_load     = (cnt == '0) || ((cnt == CNT_W'(1)) && take);
  assign code_point   = slots[0].cp;
  assign folded_point = slots[0].folded;
  assign raw_fallback = slots[0].raw;
  assign run_last     = slots[0].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= burst.count;
    end else if (take) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        slots[i] <= burst.e[i];
      end
    end else if (take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
  end

  `UTF8SD_ASSERT(count_in_range, clk, rst, 1'b1, cnt <= CNT_W'(MAX_RESULTS))
  `UTF8SD_ASSERT(final_marks_last, clk, rst, cnt == CNT_W'(1), slots[0].last)
  `UTF8SD_ASSERT(early_not_last, clk, rst, cnt > CNT_W'(1), !slots[0].last)
  `UTF8SD_ASSERT_NEXT(burst_drains, clk, rst, take && (cnt > CNT_W'(1)), cnt == $past(cnt) - 1'b1)

endmodule

/* rtl/core/utf8_stream_decode_fold.sv */
// UTF-8 stream decoder with lower-case fold.
// Input channel: one byte per transfer (data_byte, end_of_string) on in_valid/in_ready.
// Output channel: one code point per transfer (code_point, folded_point,
// raw_fallback, run_last) on out_valid/out_ready.
// A byte enters an input register; once the result register can load, the
// decoder works out all of its results at once and loads them into a four-entry
// result register. A byte gives zero to four results; run_last marks the final
// one of a byte. Throughput is one byte per cycle while each byte gives at most
// one result and the receiver is ready; a byte with more results holds the result
// register until all leave by its single output port. A byte that only holds
// part of a sequence gives none. When the receiver stalls, the result register
// holds and the input register fills; in_ready falls once both are occupied, and
// no data is lost. Reset (rst, synchronous) empties both registers and clears the
// held sequence.
// Depends on utf8sd_pkg, utf8sd_decode and utf8sd_burst.
module utf8_stream_decode_fold (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   data_byte,
  input  logic                         end_of_string,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [utf8sd_pkg::CP_W-1:0]  code_point,
  output logic [utf8sd_pkg::CP_W-1:0]  folded_point,
  output logic                         raw_fallback,
  output logic                         run_last
);
  import utf8sd_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eos;
  logic       can_load;
  logic       consume;
  burst_t     burst;

  assign consume  = in_full && can_load;
  assign in_ready = !in_full || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (consume) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= data_byte;
      in_eos  <= end_of_string;
    end
  end

  utf8sd_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .advance       (consume),
    .data_byte     (in_byte),
    .end_of_string (in_eos),
    .burst         (burst)
  );

  utf8sd_burst u_burst (
    .clk          (clk),
    .rst          (rst),
    .load         (consume),
    .burst        (burst),
    .can_load     (can_load),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_point   (code_point),
    .folded_point (folded_point),
    .raw_fallback (raw_fallback),
    .run_last     (run_last)
  );

endmodule

/* test/utf8_stream_decode_fold_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_decode_fold: directed and random byte streams.
// Depends on utf8sd_pkg and the decoder RTL; predicts every code point and fold internally.
module utf8_stream_decode_fold_tb;
  import utf8sd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 12;

  logic            clk           = 1'b0;
  logic            rst           = 1'b1;
  logic            in_valid      = 1'b0;
  logic            in_ready;
  logic [7:0]      data_byte     = 8'h00;
  logic            end_of_string = 1'b0;
  logic            out_valid;
  logic            out_ready     = 1'b0;
  logic [CP_W-1:0] code_point;
  logic [CP_W-1:0] folded_point;
  logic            raw_fallback;
  logic            run_last;

  utf8_stream_decode_fold uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_point    (code_point),
    .folded_point  (folded_point),
    .raw_fallback  (raw_fallback),
    .run_last      (run_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Decoder state as the predictor sees it.
  logic [7:0] seq_bytes [3];
  int         seq_count = 0;
  logic [2:0] seq_len   = LEN_NONE;

  entry_t points_due [$];
  entry_t byte_points [$];
  int     mismatches  = 0;
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  int     rx_hold_req = 0;
  int     rx_hold_left = 0;

  function automatic logic [CP_W-1:0] lower_fold(input logic [CP_W-1:0] cp);
    if (cp >= 21'h00041 && cp <= 21'h0005A) return cp + 21'h20;
    if (cp >= 21'h00410 && cp <= 21'h0042F) return cp + 21'h20;
    if (cp == 21'h00401) return 21'h00451;
    return cp;
  endfunction

  function automatic void emit_point(input logic [CP_W-1:0] cp, input logic raw);
    entry_t p;
    p.cp     = cp;
    p.folded = lower_fold(cp);
    p.raw    = raw;
    p.last   = 1'b0;
    byte_points.push_back(p);
  endfunction

  function automatic void clear_sequence();
    seq_count = 0;
    seq_len   = LEN_NONE;
    for (int i = 0; i < 3; i++) seq_bytes[i] = 8'h00;
  endfunction

  function automatic void flush_sequence();
    for (int i = 0; i < seq_count; i++) emit_point(CP_W'(seq_bytes[i]), 1'b1);
    clear_sequence();
  endfunction

  function automatic void begin_sequence(input logic [7:0] b);
    logic [2:0] len;
    len = LEN_NONE;
    if (b[7] == 1'b0) begin
      emit_point(CP_W'(b), 1'b0);
      return;
    end
    if (b[7:5] == 3'b110) len = LEN_2;
    else if (b[7:4] == 4'b1110) len = LEN_3;
    else if (b[7:3] == 5'b11110) len = LEN_4;
    if (len == LEN_NONE) begin
      emit_point(CP_W'(b), 1'b1);
      return;
    end
    seq_bytes[0] = b;
    seq_count    = 1;
    seq_len      = len;
  endfunction

  function automatic logic [CP_W-1:0] join_sequence(input logic [7:0] b);
    logic [CP_W-1:0] cp;
    case (seq_len)
      LEN_2:   cp = {10'd0, seq_bytes[0][4:0], b[5:0]};
      LEN_3:   cp = {5'd0, seq_bytes[0][3:0], seq_bytes[1][5:0], b[5:0]};
      default: cp = {seq_bytes[0][2:0], seq_bytes[1][5:0], seq_bytes[2][5:0], b[5:0]};
    endcase
    return cp;
  endfunction

  // Works out every result of one accepted byte and queues them in order.
  function automatic void decode_byte(input logic [7:0] b, input logic eos);
    byte_points = {};
    if (seq_count > 0) begin
      if (b[7:6] == 2'b10) begin
        if (seq_count + 1 == int'(seq_len)) begin
          emit_point(join_sequence(b), 1'b0);
          clear_sequence();
        end else begin
          seq_bytes[seq_count] = b;
          seq_count++;
        end
      end else begin
        flush_sequence();
        begin_sequence(b);
      end
    end else begin
      clear_sequence();
      begin_sequence(b);
    end
    if (eos) flush_sequence();
    if (byte_points.size() > 0) byte_points[byte_points.size() - 1].last = 1'b1;
    foreach (byte_points[i]) points_due.push_back(byte_points[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, eos);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (points_due.size() != 0);
  endtask

  task automatic check_point();
    entry_t want;
    if (points_due.size() == 0) begin
      $error("code_point: expected no result, got %h", code_point);
      mismatches++;
      return;
    end
    want = points_due.pop_front();
    if (code_point !== want.cp) begin
      $error("code_point: expected %h, got %h", want.cp, code_point);
      mismatches++;
    end
    if (folded_point !== want.folded) begin
      $error("folded_point: expected %h, got %h", want.folded, folded_point);
      mismatches++;
    end
    if (raw_fallback !== want.raw) begin
      $error("raw_fallback: expected %b, got %b", want.raw, raw_fallback);
      mismatches++;
    end
    if (run_last !== want.last) begin
      $error("run_last: expected %b, got %b", want.last, run_last);
      mismatches++;
    end
  endtask

  // Receiver: checks each transfer and decides ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_point();
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("utf8_stream_decode_fold_tb: FAIL");
    $finish;
  end

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  function automatic logic [7:0] lead_byte(input int len);
    case (len)
      2:       return 8'hC0 | 8'($urandom_range(31));
      3:       return 8'hE0 | 8'($urandom_range(15));
      default: return 8'hF0 | 8'($urandom_range(7));
    endcase
  endfunction

  task automatic test_ascii_fold();
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_multibyte();
    send_byte(8'hD0, 1'b0); send_byte(8'h90, 1'b0);
    send_byte(8'hD0, 1'b0); send_byte(8'hAF, 1'b0);
    send_byte(8'hD0, 1'b0); send_byte(8'h81, 1'b0);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
    // Largest value a four-byte lead can carry.
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
  endtask

  task automatic test_raw_bytes();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'h41, 1'b0);
  endtask

  task automatic test_end_flush();
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b1);
  endtask

  task automatic test_random_text(input int n_bytes);
    logic [7:0] chunk [$];
    logic [7:0] b;
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < n_bytes) begin
      chunk = {};
      kind  = $urandom_range(99);
      if (kind < 20) begin
        // Lands on the Cyrillic block around the fold ranges.
        chunk.push_back(8'hD0 | 8'($urandom_range(1)));
        chunk.push_back(cont_byte());
      end else if (kind < 40) begin
        chunk.push_back(8'($urandom_range(127)));
      end else if (kind < 80) begin
        len = $urandom_range(4, 2);
        chunk.push_back(lead_byte(len));
        for (int i = 1; i < len; i++) chunk.push_back(cont_byte());
      end else if (kind < 92) begin
        len = $urandom_range(4, 2);
        chunk.push_back(lead_byte(len));
        for (int i = $urandom_range(len - 2); i > 0; i--) chunk.push_back(cont_byte());
        do b = 8'($urandom_range(255)); while (b[7:6] == 2'b10);
        chunk.push_back(b);
      end else begin
        chunk.push_back(8'($urandom_range(255)));
      end
      foreach (chunk[i]) begin
        send_byte(chunk[i], $urandom_range(11) == 0);
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_hold_req = 150;
    // Random bytes while the receiver holds off, so the result register and input register both fill.
    for (int i = 0; i < 16; i++) send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 30;
    rx_idle_pct = 51;
    test_ascii_fold();
    test_multibyte();
    test_raw_bytes();
    test_end_flush();
    wait_drained();

    test_random_text(62);
    wait_drained();

    tx_idle_pct = 51;
    rx_idle_pct = 30;
    test_random_text(62);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_text(62);
    test_backpressure();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("utf8_stream_decode_fold_tb: PASS");
    end else begin
      $display("utf8_stream_decode_fold_tb: FAIL");
    end
    $finish;
  end

endmodule
